// File: rtl/mmh_pkg.sv
package mmh_pkg;

    localparam int CAPACITY_DEF = 1023;
    localparam int KEY_W = 32;
    localparam int COUNT_W = 10;
    localparam int STATUS_W = 2;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL = 2'd2,
        ST_RSVD = 2'd3
    } status_t;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // a beats b: smaller on min levels, larger on max levels
    function automatic logic beats(input logic min_lvl, input logic signed [KEY_W-1:0] a,
                                   input logic signed [KEY_W-1:0] b);
        beats = min_lvl ? (a < b) : (a > b);
    endfunction

endpackage

// File: rtl/mmh_ram.sv
module mmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/min_max_heap_engine_unit.sv
// Min-max heap of signed 32-bit keys held in one single-port-read RAM with a
// registered read. Each transfer on s_ inserts (op 0) or removes the first
// entry equal to key (op 1) and yields one m_ transfer with status, count and
// current min/max. One operation is in flight at a time. Each heap read takes
// an address and then its data. An insert climbs the heap level by level. A
// remove searches the entries in turn, then sifts down (six reads per level)
// and sifts up after it; every operation ends by refreshing min/max and
// presenting the result. No clearing pass after reset: count starts at zero.
module min_max_heap_engine_unit #(
    parameter int CAPACITY = mmh_pkg::CAPACITY_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_op,
    input  logic signed [mmh_pkg::KEY_W-1:0]    s_key,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [mmh_pkg::STATUS_W-1:0]        m_status,
    output logic [mmh_pkg::COUNT_W-1:0]         m_count,
    output logic signed [mmh_pkg::KEY_W-1:0]    m_min_key,
    output logic signed [mmh_pkg::KEY_W-1:0]    m_max_key
);

    localparam int DEPTH = CAPACITY + 1;
    localparam int AW = $clog2(DEPTH);
    // positions up to 4*CAPACITY+3 fit in PW bits
    localparam int PW = AW + 3;
    localparam int KW = mmh_pkg::KEY_W;
    localparam int COUNT_W_T = mmh_pkg::COUNT_W;

    typedef enum logic [15:0] {
        S_IDLE    = 16'h0001,
        S_RD      = 16'h0002,
        S_WAIT    = 16'h0004,
        S_SCAN    = 16'h0008,
        S_UP      = 16'h0010,
        S_UPCMP   = 16'h0020,
        S_DN      = 16'h0040,
        S_DNCMP   = 16'h0080,
        S_DNFIX   = 16'h0100,
        S_WR      = 16'h0200,
        S_MM      = 16'h0400,
        S_OUT     = 16'h0800,
        S_MOVE    = 16'h1000,
        S_DNSWP   = 16'h2000,
        S_UPSWP   = 16'h4000,
        S_FIXCMP  = 16'h8000
    } state_t;

    state_t state_reg, state_next, ret_reg, ret_next;

    logic [PW-1:0] cnt_reg, cnt_next;
    logic signed [KW-1:0] key_reg, key_next;
    logic [PW-1:0] pos_reg, pos_next;       // current node
    logic [PW-1:0] xpos_reg, xpos_next;     // where the moved entry rests
    logic signed [KW-1:0] mv_reg, mv_next;  // value of the moved entry
    logic [PW-1:0] best_reg, best_next;
    logic signed [KW-1:0] bval_reg, bval_next;
    logic signed [KW-1:0] pval_reg, pval_next;
    logic signed [KW-1:0] aval_reg, aval_next;
    logic [2:0] k_reg, k_next;              // read slot counter
    logic [PW-1:0] raddr_reg, raddr_next;
    logic [1:0] status_reg, status_next;
    logic signed [KW-1:0] mn_reg, mn_next, mx_reg, mx_next;
    logic mval_reg, mval_next;

    // write queue: up to two pending writes issued one per cycle
    logic [PW-1:0] wa0_reg, wa0_next, wa1_reg, wa1_next;
    logic signed [KW-1:0] wd0_reg, wd0_next, wd1_reg, wd1_next;
    logic [1:0] wn_reg, wn_next;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [KW-1:0] wdata, rdata;
    logic signed [KW-1:0] rd;

    assign rd = signed'(rdata);

    mmh_ram #(.WIDTH(KW), .DEPTH(DEPTH)) u_ram (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    function automatic logic min_lvl(input logic [PW-1:0] p);
        logic m;
        m = 1'b1;
        for (int i = 1; i < PW; i++) begin
            if (p >= (PW'(1) << i)) begin
                m = ~m;
            end
        end
        return m;
    endfunction

    assign s_ready = (state_reg == S_IDLE) && !mval_reg;
    assign m_valid = mval_reg;
    assign m_status = status_reg;
    assign m_count = COUNT_W_T'(cnt_reg);
    assign m_min_key = mn_reg;
    assign m_max_key = mx_reg;

    assign raddr = raddr_reg[AW-1:0];
    assign we = (wn_reg != 2'd0);
    assign waddr = wa0_reg[AW-1:0];
    assign wdata = wd0_reg;

    logic up_min;
    logic [PW-1:0] par, gp;
    assign par = pos_reg >> 1;
    assign gp = pos_reg >> 2;
    assign up_min = min_lvl(par);

    logic [PW-1:0] cand;
    always_comb begin
        unique case (k_reg)
            3'd0: cand = pos_reg << 1;
            3'd1: cand = (pos_reg << 1) + PW'(1);
            3'd2: cand = pos_reg << 2;
            3'd3: cand = (pos_reg << 2) + PW'(1);
            3'd4: cand = (pos_reg << 2) + PW'(2);
            3'd5: cand = (pos_reg << 2) + PW'(3);
            default: cand = pos_reg;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        ret_next = ret_reg;
        cnt_next = cnt_reg;
        key_next = key_reg;
        pos_next = pos_reg;
        xpos_next = xpos_reg;
        mv_next = mv_reg;
        best_next = best_reg;
        bval_next = bval_reg;
        pval_next = pval_reg;
        aval_next = aval_reg;
        k_next = k_reg;
        raddr_next = raddr_reg;
        status_next = status_reg;
        mn_next = mn_reg;
        mx_next = mx_reg;
        mval_next = mval_reg;
        wa0_next = wa0_reg;
        wd0_next = wd0_reg;
        wa1_next = wa1_reg;
        wd1_next = wd1_reg;
        wn_next = wn_reg;
        if (wn_reg != 2'd0) begin
            wa0_next = wa1_reg;
            wd0_next = wd1_reg;
            wn_next = wn_reg - 2'd1;
        end
        if (mval_reg && m_ready) begin
            mval_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    key_next = s_key;
                    status_next = mmh_pkg::ST_DONE;
                    if (s_op == mmh_pkg::OP_INSERT) begin
                        if (cnt_reg >= PW'(CAPACITY)) begin
                            status_next = mmh_pkg::ST_FULL;
                            state_next = S_MM;
                            k_next = 3'd0;
                        end else begin
                            cnt_next = cnt_reg + PW'(1);
                            pos_next = cnt_reg + PW'(1);
                            aval_next = s_key;
                            wa0_next = cnt_reg + PW'(1);
                            wd0_next = s_key;
                            wn_next = 2'd1;
                            state_next = S_UP;
                        end
                    end else begin
                        pos_next = PW'(1);
                        raddr_next = PW'(1);
                        if (cnt_reg == '0) begin
                            status_next = mmh_pkg::ST_NOT_FOUND;
                            state_next = S_MM;
                            k_next = 3'd0;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                // raddr_reg was issued last cycle; data for pos_reg is read in S_WAIT
                state_next = S_WAIT;
                ret_next = S_SCAN;
            end
            S_WAIT: begin
                if (ret_reg == S_SCAN) begin
                    if (rd == key_reg) begin
                        raddr_next = cnt_reg;
                        state_next = S_MOVE;
                        k_next = 3'd0;
                    end else if (pos_reg >= cnt_reg) begin
                        status_next = mmh_pkg::ST_NOT_FOUND;
                        state_next = S_MM;
                        k_next = 3'd0;
                    end else begin
                        pos_next = pos_reg + PW'(1);
                        raddr_next = pos_reg + PW'(1);
                        state_next = S_SCAN;
                    end
                end
            end
            S_MOVE: begin
                if (k_reg == 3'd0) begin
                    k_next = 3'd1;
                end else begin
                    k_next = 3'd0;
                    aval_next = rd;
                    mv_next = rd;
                    wa0_next = pos_reg;
                    wd0_next = rd;
                    wn_next = 2'd1;
                    cnt_next = cnt_reg - PW'(1);
                    xpos_next = pos_reg;
                    if (pos_reg <= cnt_reg - PW'(1)) begin
                        state_next = S_DN;
                    end else begin
                        state_next = S_MM;
                    end
                end
            end
            S_DN: begin
                // aval_reg holds value at pos_reg; read children/grandchildren
                if ((pos_reg << 1) > cnt_reg) begin
                    pos_next = xpos_reg;
                    state_next = S_UP;
                    aval_next = mv_reg;
                end else begin
                    k_next = 3'd0;
                    best_next = pos_reg << 1;
                    raddr_next = pos_reg << 1;
                    state_next = S_DNCMP;
                    ret_next = S_RD;
                end
            end
            S_DNCMP: begin
                if (ret_reg == S_RD) begin
                    ret_next = S_WAIT;
                end else begin
                    ret_next = S_RD;
                    if (cand <= cnt_reg &&
                        (k_reg == 3'd0 || mmh_pkg::beats(min_lvl(pos_reg), rd, bval_reg))) begin
                        best_next = cand;
                        bval_next = rd;
                    end
                    if (k_reg == 3'd5) begin
                        state_next = S_DNSWP;
                    end else begin
                        k_next = k_reg + 3'd1;
                        raddr_next = (k_reg == 3'd0) ? (pos_reg << 1) + PW'(1)
                                   : (k_reg == 3'd1) ? (pos_reg << 2)
                                   : (pos_reg << 2) + PW'(k_reg - 3'd1);
                        if (raddr_next > cnt_reg) begin
                            raddr_next = '0;
                        end
                    end
                end
            end
            S_DNSWP: begin
                if (!mmh_pkg::beats(min_lvl(pos_reg), bval_reg, aval_reg)) begin
                    pos_next = xpos_reg;
                    aval_next = mv_reg;
                    state_next = S_UP;
                end else begin
                    wa0_next = pos_reg;
                    wd0_next = bval_reg;
                    wa1_next = best_reg;
                    wd1_next = aval_reg;
                    wn_next = 2'd2;
                    if (xpos_reg == pos_reg) begin
                        xpos_next = best_reg;
                    end
                    if (best_reg < (pos_reg << 2)) begin
                        pos_next = (xpos_reg == pos_reg) ? best_reg : xpos_reg;
                        aval_next = mv_reg;
                        state_next = S_UP;
                    end else begin
                        raddr_next = best_reg >> 1;
                        k_next = 3'd0;
                        state_next = S_DNFIX;
                    end
                end
            end
            S_DNFIX: begin
                // wait for writes, then read parent of best
                if (wn_reg == 2'd0) begin
                    if (k_reg == 3'd0) begin
                        k_next = 3'd1;
                    end else if (k_reg == 3'd1) begin
                        k_next = 3'd2;
                    end else begin
                        state_next = S_FIXCMP;
                        pval_next = rd;
                    end
                end
            end
            S_FIXCMP: begin
                // aval_reg now sits at best_reg
                if (mmh_pkg::beats(min_lvl(pos_reg), pval_reg, aval_reg)) begin
                    wa0_next = best_reg;
                    wd0_next = pval_reg;
                    wa1_next = best_reg >> 1;
                    wd1_next = aval_reg;
                    wn_next = 2'd2;
                    aval_next = pval_reg;
                    if (xpos_reg == best_reg) begin
                        xpos_next = best_reg >> 1;
                    end
                end
                pos_next = best_reg;
                state_next = S_WR;
            end
            S_WR: begin
                if (wn_reg == 2'd0) begin
                    state_next = S_DN;
                end
            end
            S_UP: begin
                // aval_reg is the value at pos_reg
                if (wn_reg == 2'd0) begin
                    if (pos_reg <= PW'(1)) begin
                        state_next = S_MM;
                        k_next = 3'd0;
                    end else begin
                        raddr_next = par;
                        k_next = 3'd0;
                        state_next = S_UPCMP;
                    end
                end
            end
            S_UPCMP: begin
                unique case (k_reg)
                    3'd0: begin
                        k_next = 3'd1;
                        raddr_next = (gp != '0) ? gp : '0;
                    end
                    3'd1: begin
                        pval_next = rd;
                        k_next = 3'd2;
                    end
                    default: begin
                        bval_next = rd;
                        state_next = S_UPSWP;
                    end
                endcase
            end
            S_UPSWP: begin
                if (mmh_pkg::beats(up_min, aval_reg, pval_reg)) begin
                    wa0_next = pos_reg;
                    wd0_next = pval_reg;
                    wa1_next = par;
                    wd1_next = aval_reg;
                    wn_next = 2'd2;
                    pos_next = par;
                    state_next = S_UP;
                end else if (gp != '0 && mmh_pkg::beats(!up_min, aval_reg, bval_reg)) begin
                    wa0_next = pos_reg;
                    wd0_next = bval_reg;
                    wa1_next = gp;
                    wd1_next = aval_reg;
                    wn_next = 2'd2;
                    pos_next = gp;
                    state_next = S_UP;
                end else begin
                    state_next = S_MM;
                    k_next = 3'd0;
                end
            end
            S_MM: begin
                if (wn_reg == 2'd0) begin
                    unique case (k_reg)
                        3'd0: begin
                            raddr_next = PW'(1);
                            k_next = 3'd1;
                        end
                        3'd1: begin
                            raddr_next = PW'(2);
                            k_next = 3'd2;
                        end
                        3'd2: begin
                            mn_next = rd;
                            mx_next = rd;
                            raddr_next = PW'(3);
                            k_next = 3'd3;
                        end
                        3'd3: begin
                            if (cnt_reg >= PW'(2)) begin
                                mx_next = rd;
                            end
                            k_next = 3'd4;
                        end
                        default: begin
                            if (cnt_reg >= PW'(3) && rd > mx_reg) begin
                                mx_next = rd;
                            end
                            if (cnt_reg == '0) begin
                                mn_next = '0;
                                mx_next = '0;
                            end
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_OUT: begin
                mval_next = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ret_reg <= S_IDLE;
            cnt_reg <= '0;
            mval_reg <= 1'b0;
            wn_reg <= 2'd0;
            k_reg <= 3'd0;
        end else begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            cnt_reg <= cnt_next;
            mval_reg <= mval_next;
            wn_reg <= wn_next;
            k_reg <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        pos_reg <= pos_next;
        xpos_reg <= xpos_next;
        mv_reg <= mv_next;
        best_reg <= best_next;
        bval_reg <= bval_next;
        pval_reg <= pval_next;
        aval_reg <= aval_next;
        raddr_reg <= raddr_next;
        status_reg <= status_next;
        mn_reg <= mn_next;
        mx_reg <= mx_next;
        wa0_reg <= wa0_next;
        wd0_reg <= wd0_next;
        wa1_reg <= wa1_next;
        wd1_reg <= wd1_next;
    end

    a_cnt_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= PW'(CAPACITY))
        else $error("count beyond capacity");

    a_no_take_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_valid && s_ready) || !mval_reg)
        else $error("input taken while result pending");

    a_out_no_writes: assert property (@(posedge aclk) disable iff (!aresetn)
        !(state_reg == S_OUT) || wn_reg == 2'd0)
        else $error("result with writes pending");

endmodule
